[sv/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, operation codes and constants of the byte ring buffer with
// peek and pattern search.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_PATTERN = 8;
    localparam int CFG_DW      = 64;
    localparam int LEN_W       = 4;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN = 1'b0;
    localparam t_cfg_idx CFG_LENGTH  = 1'b1;

    typedef logic [2:0] t_func;
    localparam t_func FUNC_PUT     = 3'd0;
    localparam t_func FUNC_GET     = 3'd1;
    localparam t_func FUNC_PEEK    = 3'd2;
    localparam t_func FUNC_DISCARD = 3'd3;
    localparam t_func FUNC_SEARCH  = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_MISS   = 2'd1;
    localparam t_status ST_BADCNT = 2'd2;

    localparam logic signed [11:0] FOUND_NONE = -12'sd1;

    typedef struct packed {
        t_func              func;
        logic [7:0]         data_byte;
        logic signed [11:0] offset;
    } t_in;

    typedef struct packed {
        logic [7:0]         read_byte;
        t_status            status;
        logic signed [11:0] found_position;
        logic [10:0]        fill_level;
        logic [10:0]        free_space;
    } t_out;

endpackage

[sv/brb_ptr_unit.sv]
// ----------------------------------------------------------------------------
// brb_ptr_unit
// Shared ring address adder: base plus offset, wrapped once at DEPTH.
// ----------------------------------------------------------------------------
module brb_ptr_unit #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0]   i_base,
    input  logic [$clog2(DEPTH+1)-1:0] i_off,
    output logic [$clog2(DEPTH)-1:0]   o_addr
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    logic [PW:0] sum;

    // base < DEPTH and offset <= DEPTH, so one subtract is enough
    always_comb begin
        sum = (PW+1)'(i_base) + (PW+1)'(i_off);
        if (sum >= (PW+1)'(DEPTH)) begin
            o_addr = AW'(sum - (PW+1)'(DEPTH));
        end else begin
            o_addr = AW'(sum);
        end
    end

endmodule

[sv/brb_cfg.sv]
// ----------------------------------------------------------------------------
// brb_cfg
// Search pattern registers; the pattern length is saturated on the way out.
// ----------------------------------------------------------------------------
module brb_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  brb_pkg::t_cfg_idx            i_idx,
    input  logic [brb_pkg::CFG_DW-1:0]   i_wdata,
    output logic [brb_pkg::CFG_DW-1:0]   o_pattern,
    output logic [brb_pkg::LEN_W-1:0]    o_len
);
    import brb_pkg::*;

    logic [CFG_DW-1:0] r_pattern;
    logic [LEN_W-1:0]  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
        end else if (i_we) begin
            case (i_idx)
                CFG_PATTERN: r_pattern <= i_wdata;
                CFG_LENGTH:  r_len     <= i_wdata[LEN_W-1:0];
                default:     r_len     <= r_len;
            endcase
        end
    end

    assign o_pattern = r_pattern;
    assign o_len     = (r_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_len;

endmodule

[sv/byte_ring_buffer_with_peek_search_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek_search_unit
// Circular byte FIFO with put, get, peek, discard and pattern search.
// Steps, start to result strobe: put, discard and failed ops finish in EXEC;
// get and peek add the RD state; search adds SRD then SCMP for each byte compared
// (one storage read and one compare per byte, up to DEPTH x pattern length).
// One item at a time; busy is high until the result beat, and a new start
// is taken in the cycle the result strobe is shown. The receiver cannot stall.
// Reset clears pointers, fill level and pattern registers; storage is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek_search_unit #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  brb_pkg::t_in                i_item,
    output logic                        o_valid,
    output brb_pkg::t_out               o_result,
    input  logic                        i_cfg_we,
    input  brb_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [brb_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = ((PW > 12) ? PW : 12) + 2;
    localparam int SW = PW + LEN_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SCMP = 3'd4;

    logic [2:0]        r_state, n_state;
    t_in               r_item;
    logic [AW-1:0]     r_rd, n_rd;
    logic [PW-1:0]     r_fill, n_fill;
    logic [PW-1:0]     r_i, n_i;
    logic [PW-1:0]     r_k, n_k;
    logic [LEN_W-1:0]  r_j, n_j;
    logic              r_valid, n_valid;
    t_out              r_out, n_out;

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rdata;
    logic              mem_we;

    logic [PW-1:0]     ptr_off;
    logic [AW-1:0]     ptr_addr;

    logic [CFG_DW-1:0] pattern;
    logic [LEN_W-1:0]  pat_len;
    logic [7:0]        pat_byte;

    logic signed [CW-1:0] off_s, back_s, fill_s, len_s;
    logic                 peek_ok, disc_ok, srch_ok, next_fits;

    brb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_idx     (i_cfg_idx),
        .i_wdata   (i_cfg_wdata),
        .o_pattern (pattern),
        .o_len     (pat_len)
    );

    brb_ptr_unit #(.DEPTH(DEPTH)) u_ptr (
        .i_base (r_rd),
        .i_off  (ptr_off),
        .o_addr (ptr_addr)
    );

    // Range checks in a signed domain wide enough for offset and fill
    always_comb begin
        off_s   = CW'(r_item.offset);
        back_s  = -off_s;
        fill_s  = CW'(r_fill);
        len_s   = CW'(pat_len);
        peek_ok = (off_s >= 0) ? (off_s < fill_s) : (back_s <= fill_s);
        disc_ok = (off_s >= 0) && (off_s <= fill_s);
        srch_ok = (off_s >= 0) && ((off_s + len_s) <= fill_s);
        next_fits = (SW'(r_i) + SW'(1) + SW'(pat_len)) <= SW'(r_fill);
        pat_byte  = pattern[r_j[2:0]*8 +: 8];
    end

    // Offset into the shared adder, relative to the read pointer
    always_comb begin
        if (r_state == S_SRD) begin
            ptr_off = r_k;
        end else begin
            case (r_item.func)
                FUNC_PUT:     ptr_off = r_fill;
                FUNC_PEEK:    ptr_off = (off_s >= 0) ? PW'(off_s)
                                                     : r_fill - PW'(back_s);
                FUNC_DISCARD: ptr_off = PW'(off_s);
                default:      ptr_off = '0;
            endcase
        end
    end

    assign mem_we = (r_state == S_EXEC) && (r_item.func == FUNC_PUT) &&
                    (r_fill != PW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ptr_addr] <= r_item.data_byte;
        end
        r_rdata <= r_mem[ptr_addr];
    end

    always_comb begin
        n_state = r_state;
        n_rd    = r_rd;
        n_fill  = r_fill;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_valid = 1'b0;
        n_out   = r_out;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out.read_byte      = '0;
                n_out.status         = ST_OK;
                n_out.found_position = '0;
                n_valid              = 1'b1;
                n_state              = S_IDLE;
                case (r_item.func)
                    FUNC_PUT: begin
                        if (r_fill == PW'(DEPTH)) begin
                            n_out.status = ST_MISS;
                        end else begin
                            n_out.read_byte = r_item.data_byte;
                            n_fill          = r_fill + 1'b1;
                        end
                    end
                    FUNC_GET: begin
                        if (r_fill == '0) begin
                            n_out.status = ST_MISS;
                        end else begin
                            n_valid = 1'b0;
                            n_state = S_RD;
                        end
                    end
                    FUNC_PEEK: begin
                        if (!peek_ok) begin
                            n_out.status = ST_MISS;
                        end else begin
                            n_valid = 1'b0;
                            n_state = S_RD;
                        end
                    end
                    FUNC_DISCARD: begin
                        if (!disc_ok) begin
                            n_out.status = ST_BADCNT;
                        end else begin
                            n_rd   = ptr_addr;
                            n_fill = r_fill - PW'(off_s);
                        end
                    end
                    FUNC_SEARCH: begin
                        if (!srch_ok) begin
                            n_out.status         = ST_MISS;
                            n_out.found_position = FOUND_NONE;
                        end else if (pat_len == '0) begin
                            n_out.found_position = r_item.offset;
                        end else begin
                            n_i     = PW'(off_s);
                            n_k     = PW'(off_s);
                            n_j     = '0;
                            n_valid = 1'b0;
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        n_out.status = ST_OK;
                    end
                endcase
            end
            S_RD: begin
                n_out.read_byte = r_rdata;
                if (r_item.func == FUNC_GET) begin
                    n_rd   = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
                    n_fill = r_fill - 1'b1;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_rdata == pat_byte) begin
                    if (LEN_W'(r_j + 1'b1) == pat_len) begin
                        n_out.found_position = 12'(r_i);
                        n_valid              = 1'b1;
                        n_state              = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_k     = r_k + 1'b1;
                        n_state = S_SRD;
                    end
                end else if (next_fits) begin
                    // slide the window by one byte and restart the compare
                    n_i     = r_i + 1'b1;
                    n_k     = r_i + 1'b1;
                    n_j     = '0;
                    n_state = S_SRD;
                end else begin
                    n_out.status         = ST_MISS;
                    n_out.found_position = FOUND_NONE;
                    n_valid              = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.fill_level = 11'(n_fill);
        n_out.free_space = 11'(PW'(DEPTH) - n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_item <= i_item;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while an item is still at work");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PW'(DEPTH))
        else $error("fill level beyond depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_badcnt_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_BADCNT) |-> (r_item.func == FUNC_DISCARD))
        else $error("bad count status from an op other than discard");

endmodule
